@@ rtl/pscd_pkg.sv @@
`default_nettype none
package pscd_pkg;

  // Fraction bits of the projection factor t (Q0.24)
  localparam int T_BITS = 24;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_A_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_A_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_B_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SEG_B_Y = 2'd3;

  // Which part of the segment is nearest
  typedef enum logic [1:0] {
    REGION_B   = 2'd0,
    REGION_A   = 2'd1,
    REGION_INT = 2'd2
  } region_t;

endpackage
`default_nettype wire

@@ rtl/pscd_ifs.sv @@
`default_nettype none
interface pscd_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  modport source (output valid, query_x, query_y, input ready);
  modport sink (input valid, query_x, query_y, output ready);
endinterface

interface pscd_out_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   region;
  logic signed [COORD_BITS-1:0] near_x;
  logic signed [COORD_BITS-1:0] near_y;
  logic [2*COORD_BITS+1:0]      dist_sq;
  logic [COORD_BITS:0]          dist_res;
  modport source (output valid, region, near_x, near_y, dist_sq, dist_res, input ready);
  modport sink (input valid, region, near_x, near_y, dist_sq, dist_res, output ready);
endinterface

interface pscd_cfg_if #(parameter int COORD_BITS = 24);
  import pscd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/point_segment_closest_distance_top.sv @@
`default_nettype none
// Closest point on segment AB to a stream of query points.
//
// cfg: register writes, index 0..3 = A.x, A.y, B.x, B.y (signed Q15.8 at the
//   default width). Write only while no query is in flight; ready is always high.
// query: one point per transfer (query_x, query_y).
// result: region (0 end B, 1 end A, 2 interior), nearest point, squared
//   distance and its floor square root, one result per query, in order.
//
// Throughput is one query per cycle while the receiver takes results: every
// stage is a register, with 24 stages of the restoring divider for t and 25
// stages of the digit-by-digit square root.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and query.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and the endpoint registers to zero. Derived
// segment terms (B-A, |B-A|^2) follow a write through the square registers and then len2.
module point_segment_closest_distance_top #(
  parameter int COORD_BITS = 24
) (
  input  wire         clk,
  input  wire         rst,
  pscd_cfg_if.sink    cfg,
  pscd_in_if.sink     query,
  pscd_out_if.source  result
);
  import pscd_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int D  = C + 1;       // difference width
  localparam int P  = 2 * D;       // product width
  localparam int S  = P + 1;       // dot sum width
  localparam int LW = 2 * C + 2;   // length squared / distance squared width
  localparam int T  = T_BITS;
  localparam int R  = C + 1;       // square root digits
  localparam int MW = T + D;       // scaled offset product width
  localparam logic [MW:0] HALF = (MW + 1)'(1) << (T - 1);

  // Endpoint registers
  logic signed [C-1:0] ax, ay, bx, by;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0;
      ay <= '0;
      bx <= '0;
      by <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SEG_A_X: ax <= cfg.data;
        CFG_SEG_A_Y: ay <= cfg.data;
        CFG_SEG_B_X: bx <= cfg.data;
        CFG_SEG_B_Y: by <= cfg.data;
        default: ;
      endcase
    end
  end

  // Segment terms, static while queries are in flight
  logic signed [D-1:0] vx, vy;
  logic signed [P-1:0] vx_sq, vy_sq;
  logic [LW-1:0]       len2;
  logic [D-1:0]        vx_mag, vy_mag;
  logic                vx_neg, vy_neg;

  assign vx = D'(bx) - D'(ax);
  assign vy = D'(by) - D'(ay);

  always_ff @(posedge clk) begin
    vx_sq  <= vx * vx;
    vy_sq  <= vy * vy;
    len2   <= LW'($unsigned(vx_sq)) + LW'($unsigned(vy_sq));
    vx_neg <= vx[D-1];
    vy_neg <= vy[D-1];
    vx_mag <= vx[D-1] ? D'(-vx) : D'(vx);
    vy_mag <= vy[D-1] ? D'(-vy) : D'(vy);
  end

  // Global advance: move when the output register is empty or taken
  logic en;
  logic o_vld;
  assign en          = !o_vld || result.ready;
  assign query.ready = en;

  // Stage 1: capture query
  logic                s1_vld;
  logic signed [C-1:0] s1_qx, s1_qy;
  // Stage 2: differences to both ends
  logic                s2_vld;
  logic signed [C-1:0] s2_qx, s2_qy;
  logic signed [D-1:0] s2_dbx, s2_dby, s2_dax, s2_day;
  // Stage 3: dot product terms
  logic                s3_vld;
  logic signed [C-1:0] s3_qx, s3_qy;
  logic signed [P-1:0] s3_pbx, s3_pby, s3_pax, s3_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= query.valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_qx  <= query.query_x;
      s1_qy  <= query.query_y;
      s2_qx  <= s1_qx;
      s2_qy  <= s1_qy;
      s2_dbx <= D'(s1_qx) - D'(bx);
      s2_dby <= D'(s1_qy) - D'(by);
      s2_dax <= D'(s1_qx) - D'(ax);
      s2_day <= D'(s1_qy) - D'(ay);
      s3_qx  <= s2_qx;
      s3_qy  <= s2_qy;
      s3_pbx <= vx * s2_dbx;
      s3_pby <= vy * s2_dby;
      s3_pax <= vx * s2_dax;
      s3_pay <= vy * s2_day;
    end
  end

  // Stage 4: sum dots, pick region; feeds divider slot 0
  logic signed [S-1:0] dot_a, dot_b;
  region_t             rg4;

  assign dot_b = S'(s3_pbx) + S'(s3_pby);
  assign dot_a = S'(s3_pax) + S'(s3_pay);

  always_comb begin
    if (!dot_b[S-1]) begin
      rg4 = REGION_B;
    end else if (dot_a[S-1] || dot_a == '0) begin
      rg4 = REGION_A;
    end else begin
      rg4 = REGION_INT;
    end
  end

  // Divider pipeline: slot 0 from stage 4, slot k+1 after k+1 quotient bits
  logic                dv_vld [0:T];
  logic [LW-1:0]       dv_r   [0:T];
  logic [T-1:0]        dv_q   [0:T];
  region_t             dv_rg  [0:T];
  logic signed [C-1:0] dv_qx  [0:T];
  logic signed [C-1:0] dv_qy  [0:T];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]  <= dot_a[LW-1:0];
      dv_q[0]  <= '0;
      dv_rg[0] <= rg4;
      dv_qx[0] <= s3_qx;
      dv_qy[0] <= s3_qy;
    end
  end

  for (genvar k = 0; k < T; k++) begin : g_div
    logic [LW:0] two;
    logic        ge;

    assign two = {dv_r[k], 1'b0};
    assign ge  = two >= {1'b0, len2};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    // One restoring step: double, subtract when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[k+1]  <= ge ? LW'(two - {1'b0, len2}) : two[LW-1:0];
        dv_q[k+1]  <= {dv_q[k][T-2:0], ge};
        dv_rg[k+1] <= dv_rg[k];
        dv_qx[k+1] <= dv_qx[k];
        dv_qy[k+1] <= dv_qy[k];
      end
    end
  end

  // Stage M: scale t by |V|
  logic                m_vld;
  region_t             m_rg;
  logic signed [C-1:0] m_qx, m_qy;
  logic [MW-1:0]       m_px, m_py;
  // Stage N: round, add to A, select nearest point
  logic                n_vld;
  region_t             n_rg;
  logic signed [C-1:0] n_qx, n_qy, n_nx, n_ny;
  // Stage X: distance components
  logic                x_vld;
  region_t             x_rg;
  logic signed [C-1:0] x_nx, x_ny;
  logic signed [D-1:0] x_dx, x_dy;
  // Stage Q: squares
  logic                q_vld;
  region_t             q_rg;
  logic signed [C-1:0] q_nx, q_ny;
  logic signed [P-1:0] q_sx, q_sy;

  logic [MW:0]         rsum_x, rsum_y;
  logic [D-1:0]        rnd_x, rnd_y;
  logic signed [D:0]   off_x, off_y, int_x, int_y;
  logic signed [C-1:0] nx_sel, ny_sel;

  assign rsum_x = (MW + 1)'(m_px) + HALF;
  assign rsum_y = (MW + 1)'(m_py) + HALF;
  assign rnd_x  = rsum_x[MW-1:T];
  assign rnd_y  = rsum_y[MW-1:T];
  assign off_x  = vx_neg ? -$signed({1'b0, rnd_x}) : $signed({1'b0, rnd_x});
  assign off_y  = vy_neg ? -$signed({1'b0, rnd_y}) : $signed({1'b0, rnd_y});
  assign int_x  = (D + 1)'(ax) + off_x;
  assign int_y  = (D + 1)'(ay) + off_y;

  always_comb begin
    case (m_rg)
      REGION_B: begin
        nx_sel = bx;
        ny_sel = by;
      end
      REGION_A: begin
        nx_sel = ax;
        ny_sel = ay;
      end
      default: begin
        nx_sel = int_x[C-1:0];
        ny_sel = int_y[C-1:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
      n_vld <= 1'b0;
      x_vld <= 1'b0;
      q_vld <= 1'b0;
    end else if (en) begin
      m_vld <= dv_vld[T];
      n_vld <= m_vld;
      x_vld <= n_vld;
      q_vld <= x_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_rg <= dv_rg[T];
      m_qx <= dv_qx[T];
      m_qy <= dv_qy[T];
      m_px <= dv_q[T] * vx_mag;
      m_py <= dv_q[T] * vy_mag;
      n_rg <= m_rg;
      n_qx <= m_qx;
      n_qy <= m_qy;
      n_nx <= nx_sel;
      n_ny <= ny_sel;
      x_rg <= n_rg;
      x_nx <= n_nx;
      x_ny <= n_ny;
      x_dx <= D'(n_qx) - D'(n_nx);
      x_dy <= D'(n_qy) - D'(n_ny);
      q_rg <= x_rg;
      q_nx <= x_nx;
      q_ny <= x_ny;
      q_sx <= x_dx * x_dx;
      q_sy <= x_dy * x_dy;
    end
  end

  // Square root pipeline: slot 0 holds the squared distance
  logic                sq_vld [0:R];
  logic [LW-1:0]       sq_x   [0:R];
  logic [LW-1:0]       sq_res [0:R];
  logic [LW-1:0]       sq_dsq [0:R];
  region_t             sq_rg  [0:R];
  logic signed [C-1:0] sq_nx  [0:R];
  logic signed [C-1:0] sq_ny  [0:R];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x[0]   <= LW'($unsigned(q_sx)) + LW'($unsigned(q_sy));
      sq_dsq[0] <= LW'($unsigned(q_sx)) + LW'($unsigned(q_sy));
      sq_res[0] <= '0;
      sq_rg[0]  <= q_rg;
      sq_nx[0]  <= q_nx;
      sq_ny[0]  <= q_ny;
    end
  end

  for (genvar k = 0; k < R; k++) begin : g_sqrt
    localparam logic [LW-1:0] SQ_BIT = LW'(1) << (2 * (R - 1 - k));
    logic [LW:0] trial;
    logic        ge;

    assign trial = (LW + 1)'(sq_res[k]) + (LW + 1)'(SQ_BIT);
    assign ge    = (LW + 1)'(sq_x[k]) >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    // One root digit: subtract the trial when it fits
    always_ff @(posedge clk) begin
      if (en) begin
        sq_x[k+1]   <= ge ? LW'((LW + 1)'(sq_x[k]) - trial) : sq_x[k];
        sq_res[k+1] <= ge ? (sq_res[k] >> 1) + SQ_BIT : sq_res[k] >> 1;
        sq_dsq[k+1] <= sq_dsq[k];
        sq_rg[k+1]  <= sq_rg[k];
        sq_nx[k+1]  <= sq_nx[k];
        sq_ny[k+1]  <= sq_ny[k];
      end
    end
  end

  // Output register
  region_t             o_rg;
  logic signed [C-1:0] o_nx, o_ny;
  logic [LW-1:0]       o_dsq;
  logic [R-1:0]        o_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (en) begin
      o_vld <= sq_vld[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_rg  <= sq_rg[R];
      o_nx  <= sq_nx[R];
      o_ny  <= sq_ny[R];
      o_dsq <= sq_dsq[R];
      o_res <= sq_res[R][R-1:0];
    end
  end

  assign result.valid    = o_vld;
  assign result.region   = o_rg;
  assign result.near_x   = o_nx;
  assign result.near_y   = o_ny;
  assign result.dist_sq  = o_dsq;
  assign result.dist_res = o_res;

  // End regions report the stored endpoint itself
  a_end_a: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.region == REGION_A |-> result.near_x == ax && result.near_y == ay)
    else $error("end A result does not match endpoint A");

  a_end_b: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.region == REGION_B |-> result.near_x == bx && result.near_y == by)
    else $error("end B result does not match endpoint B");

  // Root is a floor: res^2 <= dsq < (res+1)^2
  a_root: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      (2 * R)'(result.dist_res) * (2 * R)'(result.dist_res) <= (2 * R)'(result.dist_sq) &&
      ((2 * R)'(result.dist_res) + 1) * ((2 * R)'(result.dist_res) + 1) >
        (2 * R)'(result.dist_sq))
    else $error("distance root out of range");

endmodule
`default_nettype wire

@@ verif/point_segment_closest_distance_top_tb.sv @@
module point_segment_closest_distance_top_tb;
  import pscd_pkg::*;

  localparam int CB = 24;
  localparam int LATENCY = 58;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]        region;
    logic [CB-1:0]     near_x;
    logic [CB-1:0]     near_y;
    logic [2*CB+1:0]   dist_sq;
    logic [CB:0]       dist_res;
  } seg_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pscd_cfg_if #(.COORD_BITS(CB)) cfg_bus ();
  pscd_in_if  #(.COORD_BITS(CB)) query_bus ();
  pscd_out_if #(.COORD_BITS(CB)) result_bus ();

  point_segment_closest_distance_top #(.COORD_BITS(CB)) u_top (
    .clk(clk), .rst(rst), .cfg(cfg_bus.sink), .query(query_bus.sink),
    .result(result_bus.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Segment endpoints as seen by the predictor
  longint a_x, a_y, b_x, b_y;
  seg_result_t nearest_q[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int result_count = 0;
  int query_count = 0;
  int cfg_count = 0;
  longint cycle_count = 0;
  int hist[3];

  function automatic longint sx(logic [CB-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, bit_v;
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v >>= 2;
    while (bit_v != 0) begin
      if (x >= r + bit_v) begin
        x -= r + bit_v;
        r = (r >> 1) + bit_v;
      end else begin
        r >>= 1;
      end
      bit_v >>= 2;
    end
    return r;
  endfunction

  // Round t*v / 2^T_BITS, ties away from zero
  function automatic longint scale_offset(longint unsigned t, longint v);
    longint unsigned mag, p;
    mag = (v < 0) ? longint'(-v) : v;
    p = (t * mag + (64'd1 << (T_BITS - 1))) >> T_BITS;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic seg_result_t nearest_point(logic [CB-1:0] qxr, logic [CB-1:0] qyr);
    seg_result_t r;
    longint qx, qy, vx, vy, dot_b, dot_a, nx, ny, dx, dy;
    longint unsigned len2, t, rem, dsq;
    qx = sx(qxr);
    qy = sx(qyr);
    vx = b_x - a_x;
    vy = b_y - a_y;
    dot_b = vx * (qx - b_x) + vy * (qy - b_y);
    dot_a = vx * (qx - a_x) + vy * (qy - a_y);
    if (dot_b >= 0) begin
      r.region = REGION_B;
      nx = b_x;
      ny = b_y;
    end else if (dot_a <= 0) begin
      r.region = REGION_A;
      nx = a_x;
      ny = a_y;
    end else begin
      len2 = longint'(vx * vx) + longint'(vy * vy);
      rem = dot_a;
      t = 0;
      for (int i = 0; i < T_BITS; i++) begin
        t <<= 1;
        if (rem >= len2 - rem) begin
          rem = rem - (len2 - rem);
          t |= 1;
        end else begin
          rem <<= 1;
        end
      end
      r.region = REGION_INT;
      nx = a_x + scale_offset(t, vx);
      ny = a_y + scale_offset(t, vy);
    end
    dx = qx - nx;
    dy = qy - ny;
    dsq = longint'(dx * dx) + longint'(dy * dy);
    r.near_x = nx[CB-1:0];
    r.near_y = ny[CB-1:0];
    r.dist_sq = dsq[2*CB+1:0];
    r.dist_res = (CB + 1)'(root_floor(dsq));
    return r;
  endfunction

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    query_bus.valid = 1'b0;
    query_bus.query_x = '0;
    query_bus.query_y = '0;
  end

  // Count cycles and stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive result ready with random stalls
  always @(negedge clk) begin
    if (rst) result_bus.ready <= 1'b0;
    else result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each result transfer against the oldest prediction
  always @(posedge clk) begin
    seg_result_t got, exp_r;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = '{result_bus.region, result_bus.near_x, result_bus.near_y,
              result_bus.dist_sq, result_bus.dist_res};
      if (nearest_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        fail_count++;
      end else begin
        exp_r = nearest_q.pop_front();
        result_count++;
        if (exp_r.region < 3) hist[exp_r.region]++;
        if (got.region !== exp_r.region)
          $display("%0t region exp %0d got %0d", $time, exp_r.region, got.region);
        if (got.near_x !== exp_r.near_x)
          $display("%0t near_x exp %h got %h", $time, exp_r.near_x, got.near_x);
        if (got.near_y !== exp_r.near_y)
          $display("%0t near_y exp %h got %h", $time, exp_r.near_y, got.near_y);
        if (got.dist_sq !== exp_r.dist_sq)
          $display("%0t dist_sq exp %0d got %0d", $time, exp_r.dist_sq, got.dist_sq);
        if (got.dist_res !== exp_r.dist_res)
          $display("%0t dist_res exp %0d got %0d", $time, exp_r.dist_res, got.dist_res);
        if (got !== exp_r) fail_count++;
      end
    end
  end

  // Hold valid across back-to-back transfers; drop it only while idle
  task automatic send_query(logic [CB-1:0] qx, logic [CB-1:0] qy);
    while ($urandom_range(99) < send_idle_pct) begin
      query_bus.valid <= 1'b0;
      @(negedge clk);
    end
    query_bus.valid <= 1'b1;
    query_bus.query_x <= qx;
    query_bus.query_y <= qy;
    @(posedge clk);
    while (!query_bus.ready) @(posedge clk);
    nearest_q = {nearest_q, nearest_point(qx, qy)};
    query_count++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    query_bus.valid <= 1'b0;
    while (nearest_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      CFG_SEG_A_X: a_x = sx(val);
      CFG_SEG_A_Y: a_y = sx(val);
      CFG_SEG_B_X: b_x = sx(val);
      default:     b_y = sx(val);
    endcase
    cfg_count++;
    @(negedge clk);
  endtask

  task automatic set_segment(logic [CB-1:0] ax, logic [CB-1:0] ay,
                             logic [CB-1:0] bx, logic [CB-1:0] by);
    drain_results();
    write_reg(CFG_SEG_A_X, ax);
    write_reg(CFG_SEG_A_Y, ay);
    write_reg(CFG_SEG_B_X, bx);
    write_reg(CFG_SEG_B_Y, by);
    cfg_bus.valid <= 1'b0;
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [CB-1:0] rand_coord(int span);
    case ($urandom_range(3))
      0: return CB'($urandom());
      1: return CB'($urandom_range(2 * span) - span);
      2: return {$urandom_range(1) ? 2'b01 : 2'b10, 22'($urandom())};
      default: return CB'($urandom_range(255) - 128);
    endcase
  endfunction

  // Directed: reset segment, extremes, ends, interior and degenerate cases
  task automatic test_directed();
    localparam logic [CB-1:0] MAXV = 24'h7fffff;
    localparam logic [CB-1:0] MINV = 24'h800000;
    send_query(24'd0, 24'd0);
    send_query(MAXV, MINV);
    set_segment(MINV, MINV, MAXV, MAXV);
    send_query(MAXV, MINV);
    send_query(MINV, MAXV);
    send_query(MAXV, MAXV);
    send_query(MINV, MINV);
    send_query(24'd0, 24'd0);
    send_query(24'd1000, -24'sd1000);
    set_segment(24'd0, 24'd0, 24'd256, 24'd0);
    send_query(-24'sd1, 24'd5);
    send_query(24'd0, 24'd5);
    send_query(24'd128, 24'd77);
    send_query(24'd256, -24'sd3);
    send_query(24'd257, 24'd0);
    send_query(24'd3, 24'd3);
    set_segment(24'd1234, -24'sd99, 24'd1234, -24'sd99);
    send_query(MAXV, MAXV);
    send_query(24'd1234, -24'sd99);
    set_segment(MAXV, MINV, MINV, MAXV);
    send_query(24'd0, 24'd0);
    send_query(MAXV, MAXV);
    send_query(MINV, MINV);
    set_segment(24'd0, 24'd0, 24'd3, 24'd1);
    send_query(24'd1, 24'd2);
    send_query(24'd2, -24'sd1);
  endtask

  // Random segments and queries from the same coordinate span, across idling and stalling phases
  task automatic test_random(int n_items);
    int span;
    logic [CB-1:0] ax, ay, bx, by;
    for (int i = 0; i < n_items; i++) begin
      if (i % 100 == 0) begin
        case ((i / 100) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
          default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
        span = (i % 300 == 0) ? 8388607 : $urandom_range(1 << $urandom_range(20, 4));
        ax = rand_coord(span);
        ay = rand_coord(span);
        bx = ($urandom_range(9) == 0) ? ax : rand_coord(span);
        by = ($urandom_range(9) == 0) ? ay : rand_coord(span);
        set_segment(ax, ay, bx, by);
      end
      send_query(rand_coord(span), rand_coord(span));
    end
  endtask

  initial begin
    a_x = 0; a_y = 0; b_x = 0; b_y = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(1650);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain_results();
    $display("%0d queries, %0d results, %0d register writes", query_count,
             result_count, cfg_count);
    $display("regions: end B %0d, end A %0d, interior %0d", hist[0], hist[1], hist[2]);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
